// ===== rtl/core/llqd_pkg.sv =====
// ----------------------------------------------------------------------------
// llqd_pkg
// Shared types and codes for the least-loaded queue dispatcher: input and
// result beats, the classified command passed from front to back, status
// and command kind codes.
// ----------------------------------------------------------------------------
package llqd_pkg;

  // Default sizing
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Depth of the command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  // Width of the effective active-queue count (register is 4 bits)
  localparam int LIVE_W = 4;

  // Largest value a result's work field can carry
  localparam logic [19:0] WORK_MAX = 20'hFFFFF;

  // Command kind codes on the input beat
  localparam logic [1:0] KIND_AUTO  = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // Status codes on the result beat
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  queue_index;
    logic [15:0] job_tag;
    logic [15:0] job_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chosen_queue;
    logic [15:0] popped_tag;
    logic [15:0] popped_time;
    logic [19:0] queue_work;
  } out_item_t;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_DISPATCH,
    OP_PUSH,
    OP_POP,
    OP_QUERY,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [2:0]          queue_index;
    logic [15:0]         job_tag;
    logic [15:0]         job_time;
    logic [LIVE_W-1:0]   live;
  } cmd_t;

endpackage

// ===== rtl/core/llqd_front.sv =====
// ----------------------------------------------------------------------------
// llqd_front
// Input side: holds the active-queue register, accepts command beats,
// classifies them (index check against the live count) and buffers them in
// a short command queue for the back end.
// ----------------------------------------------------------------------------
module llqd_front
  import llqd_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  logic      cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  logic      cmd_take
);

  localparam int PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int FILL_W = $clog2(CMDQ_DEPTH + 1);

  logic [3:0]        active_queues;
  logic [LIVE_W-1:0] live;
  cmd_t              cls;
  cmd_t              cmdq [CMDQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;

  // Hold the active-queue register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= 4'd8;
    end else if (cfg_wr_en) begin
      active_queues <= cfg_wr_data;
    end
  end

  // Clamp the register to 1..NUM_QUEUES
  always_comb begin
    if (active_queues == 4'd0) begin
      live = LIVE_W'(1);
    end else if (32'(active_queues) > NUM_QUEUES) begin
      live = LIVE_W'(NUM_QUEUES);
    end else begin
      live = LIVE_W'(active_queues);
    end
  end

  // Classify the incoming beat
  always_comb begin
    cls.queue_index = in_item.queue_index;
    cls.job_tag     = in_item.job_tag;
    cls.job_time    = in_item.job_time;
    cls.live        = live;
    case (in_item.kind)
      KIND_AUTO:  cls.op = OP_DISPATCH;
      KIND_QUERY: cls.op = OP_QUERY;
      KIND_PUSH:  cls.op = ({1'b0, in_item.queue_index} < live) ? OP_PUSH : OP_BAD;
      KIND_POP:   cls.op = ({1'b0, in_item.queue_index} < live) ? OP_POP : OP_BAD;
      default:    cls.op = OP_BAD;
    endcase
  end

  assign in_stall  = (32'(fill) == CMDQ_DEPTH);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = cmdq[rd_ptr];

  // Command queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmdq[wr_ptr] <= cls;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == CMDQ_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (cmd_take) begin
        rd_ptr <= (32'(rd_ptr) == CMDQ_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !cmd_take) begin
        fill <= fill + FILL_W'(1);
      end else if (!push && cmd_take) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/llqd_back.sv =====
// ----------------------------------------------------------------------------
// llqd_back
// Execution side: per-queue head, count and work sums, the shared job
// memory, a one-queue-per-cycle scan for the least loaded queue, and the
// result register.
// ----------------------------------------------------------------------------
module llqd_back
  import llqd_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int QW    = $clog2(NUM_QUEUES);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
  localparam int WW    = 16 + CNTW;
  localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_POP} state_t;

  state_t          state;
  cmd_t            cur;
  logic [QW-1:0]   target;
  logic [QW-1:0]   scan_idx;
  logic [WW-1:0]   best_work;

  logic [PW-1:0]   head_ptr [NUM_QUEUES];
  logic [CNTW-1:0] count    [NUM_QUEUES];
  logic [WW-1:0]   work     [NUM_QUEUES];

  logic [31:0]     job_mem  [DEPTH];
  logic [31:0]     mem_rd_data;

  logic [QW-1:0]   rd_q;
  logic [PW-1:0]   rd_head;
  logic [CNTW-1:0] rd_count;
  logic [WW-1:0]   rd_work;
  logic            out_free;
  logic            scan_last;
  logic            q_full;
  logic [31:0]     slot_sum;
  logic [PW-1:0]   tail_slot;
  logic [PW-1:0]   head_next;
  logic [AW-1:0]   base_addr;
  logic [WW-1:0]   work_add;
  logic [WW-1:0]   work_sub;
  logic [2:0]      best_q;
  logic            do_write;
  logic            do_read;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic            pop_wait;
  logic            res_load;
  out_item_t       res_item;

  // Clip a work sum to the 20-bit result field
  function automatic logic [19:0] clip_work(input logic [WW-1:0] w);
    if (32'(w) > 32'(WORK_MAX)) begin
      return WORK_MAX;
    end
    return 20'(w);
  endfunction

  // Single read port on the per-queue state
  assign rd_q     = (state == S_SCAN) ? scan_idx : target;
  assign rd_head  = head_ptr[rd_q];
  assign rd_count = count[rd_q];
  assign rd_work  = work[rd_q];

  assign out_free  = !out_valid || !out_stall;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign scan_last = (32'(scan_idx) + 32'd1 == 32'(cur.live));
  assign q_full    = (32'(rd_count) == QUEUE_DEPTH);
  assign best_q    = 3'(target);

  // A pop with entries waits in S_POP for the head entry from the registered memory read
  assign pop_wait = (state == S_EXEC) && (cur.op == OP_POP) && (rd_count != '0);
  assign res_load = out_free && (((state == S_EXEC) && !pop_wait) || (state == S_POP));

  // Tail slot and next head, wrapped by compare and subtract; base address and updated work sums
  always_comb begin
    slot_sum  = 32'(rd_head) + 32'(rd_count);
    tail_slot = (slot_sum >= QUEUE_DEPTH) ? PW'(slot_sum - QUEUE_DEPTH) : PW'(slot_sum);
    head_next = (32'(rd_head) + 32'd1 == QUEUE_DEPTH) ? '0 : rd_head + PW'(1);
    base_addr = AW'(32'(target) * QUEUE_DEPTH);
    work_add  = rd_work + WW'(cur.job_time);
    work_sub  = rd_work - WW'(mem_rd_data[15:0]);
  end

  // Memory port controls
  always_comb begin
    do_write = 1'b0;
    do_read  = 1'b0;
    wr_addr  = base_addr + AW'(tail_slot);
    rd_addr  = base_addr + AW'(rd_head);
    if (state == S_EXEC && out_free) begin
      if ((cur.op == OP_DISPATCH || cur.op == OP_PUSH) && !q_full) begin
        do_write = 1'b1;
      end
      if (cur.op == OP_POP && rd_count != '0) begin
        do_read = 1'b1;
      end
    end
  end

  // Result beat for the command in hand
  always_comb begin
    res_item              = '0;
    res_item.status       = ST_OK;
    res_item.chosen_queue = cur.queue_index;
    res_item.queue_work   = clip_work(rd_work);
    if (state == S_POP) begin
      res_item.popped_tag  = mem_rd_data[31:16];
      res_item.popped_time = mem_rd_data[15:0];
      res_item.queue_work  = clip_work(work_sub);
    end else begin
      case (cur.op)
        OP_DISPATCH, OP_PUSH: begin
          if (cur.op == OP_DISPATCH) begin
            res_item.chosen_queue = best_q;
          end
          if (q_full) begin
            res_item.status = ST_FULL;
          end else begin
            res_item.queue_work = clip_work(work_add);
          end
        end
        OP_QUERY: begin
          res_item.chosen_queue = best_q;
        end
        OP_POP: begin
          if (rd_count == '0) begin
            res_item.status = ST_EMPTY;
          end
        end
        default: begin
          res_item.status     = ST_BAD_INDEX;
          res_item.queue_work = '0;
        end
      endcase
    end
  end

  // Job memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      job_mem[wr_addr] <= {cur.job_tag, cur.job_time};
    end
    if (do_read) begin
      mem_rd_data <= job_mem[rd_addr];
    end
  end

  // Command register
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  // Sequencer, per-queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      target    <= '0;
      scan_idx  <= '0;
      best_work <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_ptr[i] <= '0;
        count[i]    <= '0;
        work[i]     <= '0;
      end
    end else begin
      // load a new result, or drop the one that is taken
      if (res_load) begin
        out_valid <= 1'b1;
        out_item  <= res_item;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_DISPATCH || cmd.op == OP_QUERY) begin
              scan_idx <= '0;
              state    <= S_SCAN;
            end else begin
              target <= QW'(cmd.queue_index);
              state  <= S_EXEC;
            end
          end
        end
        S_SCAN: begin
          // keep the lowest index among equal sums
          if (scan_idx == '0 || rd_work < best_work) begin
            best_work <= rd_work;
            target    <= scan_idx;
          end
          if (scan_last) begin
            state <= S_EXEC;
          end else begin
            scan_idx <= scan_idx + QW'(1);
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= pop_wait ? S_POP : S_IDLE;
            if ((cur.op == OP_DISPATCH || cur.op == OP_PUSH) && !q_full) begin
              count[target] <= rd_count + CNTW'(1);
              work[target]  <= work_add;
            end
          end
        end
        S_POP: begin
          if (out_free) begin
            head_ptr[target] <= head_next;
            count[target]    <= rd_count - CNTW'(1);
            work[target]     <= work_sub;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/least_loaded_queue_dispatch.sv =====
// ----------------------------------------------------------------------------
// least_loaded_queue_dispatch
// Keeps a set of job FIFOs with a running work sum each; dispatches jobs to
// the least loaded active queue, pushes and pops named queues, and reports
// the least loaded queue.
//
//   channel  | signals                          | beat taken when
//   ---------+----------------------------------+---------------------------
//   input    | in_valid, in_stall, in_item      | in_valid && !in_stall
//   result   | out_valid, out_stall, out_item   | out_valid && !out_stall
//   config   | cfg_wr_en, cfg_wr_data           | cfg_wr_en
//
// Push, bad-index and empty or full cases run through the execute state, a pop
// also through a pop state (one job memory read), dispatch and query first
// through the one-queue-per-cycle scan of the work sums over the live queues.
// The front buffers two commands, so input is still taken while the back end
// works or a result waits on out_stall, until both entries are held.
// Reset clears queue heads, counts and work sums at once; no clearing pass.
// ----------------------------------------------------------------------------
module least_loaded_queue_dispatch
  import llqd_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // Accept and classify
  llqd_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // Execute against the queues
  llqd_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
